/* rtl/sjf_nonpreemptive_scheduler_top_assert.svh */
// Assertion macros for the shortest-job-first scheduler.
// Included by the modules that check their own sequencing; no other dependencies.
`ifndef SJF_NONPREEMPTIVE_SCHEDULER_TOP_ASSERT_SVH
`define SJF_NONPREEMPTIVE_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SJF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SJF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sjf_pkg.sv */
// Shared types and constants for the shortest-job-first scheduler.
// No dependencies; imported by every module of the block.
package sjf_pkg;

  localparam int SJF_MAX_PROCS_DEF = 16;
  localparam int ID_W   = 16;
  localparam int ARR_W  = 16;
  localparam int BST_W  = 16;
  localparam int TIME_W = 21;
  localparam int SUM_W  = 25;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 152;

  typedef struct packed {
    logic [BST_W-1:0] burst;
    logic [ARR_W-1:0] arrival;
    logic [ID_W-1:0]  id;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_ARR,
    ST_ADV,
    ST_SCAN_BST,
    ST_READ,
    ST_FIN,
    ST_SUM,
    ST_EMIT
  } state_t;

  typedef enum logic {
    CMP_MIN_ARR,
    CMP_MIN_BST
  } cmp_mode_t;

  typedef struct packed {
    cmp_mode_t         mode;
    logic              cand_ok;
    logic              found;
    logic [ARR_W-1:0]  cand_arr;
    logic [BST_W-1:0]  cand_bst;
    logic [ARR_W-1:0]  best_arr;
    logic [BST_W-1:0]  best_bst;
    logic [TIME_W-1:0] clock_now;
  } cmp_req_t;

  typedef struct packed {
    logic              last;
    logic [SUM_W-1:0]  total_turnaround;
    logic [SUM_W-1:0]  total_wait;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] wait_time;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] start_time;
    logic [ID_W-1:0]   sched_id;
  } result_t;

endpackage

/* rtl/sjf_job_mem.sv */
// Job store: one write port, one read port with registered read data.
// Depends on sjf_pkg for the job record type.
module sjf_job_mem
  import sjf_pkg::*;
#(
  parameter int DEPTH = SJF_MAX_PROCS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  job_t          wdata,
  input  logic [AW-1:0] raddr,
  output job_t          rdata
);

  job_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sjf_cmp_unit.sv */
// Shared compare unit: decides whether a scanned job replaces the current best.
// Depends on sjf_pkg for the request struct and mode codes.
module sjf_cmp_unit
  import sjf_pkg::*;
(
  input  cmp_req_t req,
  output logic     take
);

  logic elig;
  logic better;

  always_comb begin
    elig   = 1'b0;
    better = 1'b0;
    take   = 1'b0;
    unique case (req.mode)
      CMP_MIN_ARR: begin
        take = req.cand_ok && (!req.found || (req.cand_arr < req.best_arr));
      end
      CMP_MIN_BST: begin
        elig   = {{(TIME_W-ARR_W){1'b0}}, req.cand_arr} <= req.clock_now;
        // shorter burst wins; equal burst goes to the earlier arrival
        better = (req.cand_bst < req.best_bst) ||
                 ((req.cand_bst == req.best_bst) && (req.cand_arr < req.best_arr));
        take   = req.cand_ok && elig && (!req.found || better);
      end
      default: take = 1'b0;
    endcase
  end

endmodule

/* rtl/sjf_core.sv */
// Sequencer and datapath: loads jobs, scans them twice per pick through the
// shared compare unit, and forms one result per job. Depends on sjf_pkg,
// sjf_job_mem, sjf_cmp_unit and the assertion macro header.
`include "sjf_nonpreemptive_scheduler_top_assert.svh"

module sjf_core
  import sjf_pkg::*;
#(
  parameter int MAX_PROCS = SJF_MAX_PROCS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  job_t          in_job,
  input  logic          in_last,
  output logic          res_valid,
  input  logic          res_ready,
  output result_t       res
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_after;
  logic [CNT_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  k;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic              found;
  logic [IDX_W-1:0]  best_idx;
  logic [ARR_W-1:0]  best_arr;
  logic [BST_W-1:0]  best_bst;
  logic [TIME_W-1:0] clock_now;
  logic [TIME_W-1:0] finish;
  logic [TIME_W-1:0] wt;
  logic [TIME_W-1:0] tat;
  logic [SUM_W-1:0]  wait_sum;
  logic [SUM_W-1:0]  turn_sum;
  logic [ID_W-1:0]   job_id;
  logic [MAX_PROCS-1:0] done;

  logic              in_acc;
  logic              has_room;
  logic              scan_end;
  logic              final_pick;
  logic              res_acc;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_raddr;
  job_t              mem_rdata;
  cmp_req_t          cmp_req;
  logic              take;

  sjf_job_mem #(
    .DEPTH (MAX_PROCS),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (in_job),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sjf_cmp_unit u_cmp (
    .req  (cmp_req),
    .take (take)
  );

  assign has_room    = count < CNT_W'(MAX_PROCS);
  assign count_after = has_room ? count + CNT_W'(1) : count;
  assign in_acc      = in_valid && in_ready;
  assign mem_we      = in_acc && has_room;
  assign scan_end    = scan_idx == count;
  assign final_pick  = k == (count - CNT_W'(1));
  assign res_acc     = res_valid && res_ready;

  always_comb begin
    cmp_req.mode      = (state == ST_SCAN_BST) ? CMP_MIN_BST : CMP_MIN_ARR;
    cmp_req.cand_ok   = rd_vld && !done[rd_idx];
    cmp_req.found     = found;
    cmp_req.cand_arr  = mem_rdata.arrival;
    cmp_req.cand_bst  = mem_rdata.burst;
    cmp_req.best_arr  = best_arr;
    cmp_req.best_bst  = best_bst;
    cmp_req.clock_now = clock_now;
  end

  always_comb begin
    res.sched_id         = job_id;
    res.start_time       = clock_now;
    res.finish_time      = finish;
    res.wait_time        = wt;
    res.turnaround_time  = tat;
    res.total_wait       = wait_sum;
    res.total_turnaround = turn_sum + {{(SUM_W-TIME_W){1'b0}}, tat};
    res.last             = final_pick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mem_raddr  = scan_idx[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_last && (count_after != '0)) begin
          state_next = ST_SCAN_ARR;
        end
      end
      ST_SCAN_ARR: begin
        if (scan_end) begin
          state_next = ST_ADV;
        end
      end
      ST_ADV: state_next = ST_SCAN_BST;
      ST_SCAN_BST: begin
        if (scan_end) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        mem_raddr  = best_idx;
        state_next = ST_FIN;
      end
      ST_FIN: state_next = ST_SUM;
      ST_SUM: state_next = ST_EMIT;
      ST_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = final_pick ? ST_IDLE : ST_SCAN_ARR;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      done      <= '0;
      clock_now <= '0;
      wait_sum  <= '0;
      turn_sum  <= '0;
      k         <= '0;
      scan_idx  <= '0;
      rd_vld    <= 1'b0;
      found     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          scan_idx <= '0;
          rd_vld   <= 1'b0;
          found    <= 1'b0;
          k        <= '0;
          if (in_acc) begin
            // drop a job beyond capacity; the last flag still starts a schedule
            count <= count_after;
          end
        end
        ST_SCAN_ARR, ST_SCAN_BST: begin
          rd_vld   <= scan_idx < count;
          scan_idx <= scan_idx + CNT_W'(1);
          if (take) begin
            found <= 1'b1;
          end
        end
        ST_ADV: begin
          // idle processor: jump to the earliest pending arrival
          if ({{(TIME_W-ARR_W){1'b0}}, best_arr} > clock_now) begin
            clock_now <= {{(TIME_W-ARR_W){1'b0}}, best_arr};
          end
          scan_idx <= '0;
          rd_vld   <= 1'b0;
          found    <= 1'b0;
        end
        ST_FIN: done[best_idx] <= 1'b1;
        ST_SUM: wait_sum <= wait_sum + {{(SUM_W-TIME_W){1'b0}}, wt};
        ST_EMIT: begin
          if (res_acc) begin
            scan_idx <= '0;
            rd_vld   <= 1'b0;
            found    <= 1'b0;
            k        <= k + CNT_W'(1);
            if (final_pick) begin
              count     <= '0;
              done      <= '0;
              clock_now <= '0;
              wait_sum  <= '0;
              turn_sum  <= '0;
            end else begin
              clock_now <= finish;
              turn_sum  <= turn_sum + {{(SUM_W-TIME_W){1'b0}}, tat};
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers: best candidate and per-pick arithmetic.
  always_ff @(posedge clk) begin
    if (((state == ST_SCAN_ARR) || (state == ST_SCAN_BST)) && take) begin
      best_idx <= rd_idx;
      best_arr <= mem_rdata.arrival;
      best_bst <= mem_rdata.burst;
    end
    rd_idx <= scan_idx[IDX_W-1:0];
    if (state == ST_FIN) begin
      job_id <= mem_rdata.id;
      finish <= clock_now + {{(TIME_W-BST_W){1'b0}}, best_bst};
      wt     <= clock_now - {{(TIME_W-ARR_W){1'b0}}, best_arr};
    end
    if (state == ST_SUM) begin
      tat <= wt + {{(TIME_W-BST_W){1'b0}}, best_bst};
    end
  end

  `SJF_ASSERT_IMP(a_count_cap, clk, rst, 1'b1, count <= CNT_W'(MAX_PROCS),
    "job count exceeds capacity")
  `SJF_ASSERT_IMP(a_pick_found, clk, rst, state == ST_READ, found,
    "no eligible job found after clock advance")
  `SJF_ASSERT_IMP(a_pick_fresh, clk, rst, state == ST_FIN, !done[best_idx],
    "selected job already scheduled")
  `SJF_ASSERT_NXT(a_clear_after, clk, rst, res_acc && final_pick,
    (count == '0) && (done == '0) && (state == ST_IDLE),
    "state not cleared after final result")

endmodule

/* rtl/sjf_nonpreemptive_scheduler_top.sv */
// Top level of the non-preemptive shortest-job-first scheduler.
// Depends on sjf_pkg and sjf_core (which holds the job store and compare unit).
//
// Usage:
//   Input stream (s_axis_*): one transaction per job. tlast marks the final job
//   of a set and starts scheduling. Jobs beyond MAX_PROCS are dropped; a
//   dropped job with tlast still starts the schedule of the jobs stored.
//   Output stream (m_axis_*): one transaction per scheduled job in run order,
//   tlast on the final one. A set with no jobs yields no output.
//   Loading accepts one job per cycle. Each pick scans the stored jobs twice
//   through one shared comparator on one memory read port (earliest arrival,
//   then shortest eligible burst). Input ready is low from the final job until
//   the last result is handed to the output register. A stalled receiver holds
//   the output register and the sequencer waits; nothing is dropped. Reset
//   (rst, synchronous) empties the job set and the output register; the job
//   store itself is not cleared.
module sjf_nonpreemptive_scheduler_top
  import sjf_pkg::*;
#(
  parameter int MAX_PROCS = SJF_MAX_PROCS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // proc_id[15:0], arrival_time[31:16], burst_length[47:32]
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // sched_id[15:0], start_time[36:16], finish_time[57:37], wait_time[78:58],
  // turnaround_time[99:79], total_wait[124:100], total_turnaround[149:125], zero pad
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tlast
);

  job_t    in_job;
  logic    res_valid;
  logic    res_ready;
  result_t res;

  // Unpack the input transaction into a job record.
  assign in_job.id      = s_axis_tdata[ID_W-1:0];
  assign in_job.arrival = s_axis_tdata[ID_W+ARR_W-1:ID_W];
  assign in_job.burst   = s_axis_tdata[IN_W-1:ID_W+ARR_W];

  sjf_core #(
    .MAX_PROCS (MAX_PROCS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_job    (in_job),
    .in_last   (s_axis_tlast),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or draining this cycle.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {2'b00, res.total_turnaround, res.total_wait, res.turnaround_time,
                       res.wait_time, res.finish_time, res.start_time, res.sched_id};
      m_axis_tlast <= res.last;
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for sjf_nonpreemptive_scheduler_top: job sets in, schedule slots out.
// Depends on sjf_pkg and the scheduler RTL; the schedule predictor lives in a small class here.
module tb;
  import sjf_pkg::*;

  localparam int JOBS = SJF_MAX_PROCS_DEF;

  // Job-set model plus the queue of schedule slots still owed by the block.
  class schedule_board;
    logic [ID_W-1:0]  ids[JOBS];
    logic [ARR_W-1:0] arrivals[JOBS];
    logic [BST_W-1:0] bursts[JOBS];
    int               count;
    result_t          slot_q[$];
    int               errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function int pending();
      return slot_q.size();
    endfunction

    // Store the job if there is room; a job marked last closes the set.
    function void note_job(logic [ID_W-1:0] id, logic [ARR_W-1:0] arr,
                           logic [BST_W-1:0] bst, logic last);
      if (count < JOBS) begin
        ids[count]      = id;
        arrivals[count] = arr;
        bursts[count]   = bst;
        count++;
      end
      if (last)
        build_schedule();
    endfunction

    // Non-preemptive shortest-burst order; idle time jumps to the next arrival.
    function void build_schedule();
      bit                done[JOBS];
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] finish;
      logic [SUM_W-1:0]  wsum;
      logic [SUM_W-1:0]  tsum;
      logic [ARR_W-1:0]  earliest;
      bit                any;
      int                sel;
      result_t           r;
      foreach (done[i]) done[i] = 0;
      now  = '0;
      wsum = '0;
      tsum = '0;
      for (int k = 0; k < count; k++) begin
        any      = 0;
        earliest = '0;
        for (int i = 0; i < count; i++) begin
          if (!done[i]) begin
            if (!any || arrivals[i] < earliest)
              earliest = arrivals[i];
            any = 1;
          end
        end
        if (TIME_W'(earliest) > now)
          now = TIME_W'(earliest);
        sel = -1;
        for (int i = 0; i < count; i++) begin
          if (done[i] || TIME_W'(arrivals[i]) > now)
            continue;
          if (sel < 0 || bursts[i] < bursts[sel] ||
              (bursts[i] == bursts[sel] && arrivals[i] < arrivals[sel]))
            sel = i;
        end
        done[sel] = 1;
        start  = now;
        finish = start + TIME_W'(bursts[sel]);
        now    = finish;
        r.sched_id         = ids[sel];
        r.start_time       = start;
        r.finish_time      = finish;
        r.wait_time        = start - TIME_W'(arrivals[sel]);
        r.turnaround_time  = finish - TIME_W'(arrivals[sel]);
        wsum               = wsum + SUM_W'(r.wait_time);
        tsum               = tsum + SUM_W'(r.turnaround_time);
        r.total_wait       = wsum;
        r.total_turnaround = tsum;
        r.last             = (k == count - 1);
        slot_q.push_back(r);
      end
      count = 0;
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Compare one output transaction with the oldest owed slot.
    function void check_slot(logic [OUT_W-1:0] data, logic last);
      result_t r;
      if (slot_q.size() == 0) begin
        $error("output transaction with nothing owed: id %0d", data[15:0]);
        errors++;
        return;
      end
      r = slot_q.pop_front();
      check_field("sched_id",         32'(r.sched_id),         32'(data[15:0]));
      check_field("start_time",       32'(r.start_time),       32'(data[36:16]));
      check_field("finish_time",      32'(r.finish_time),      32'(data[57:37]));
      check_field("wait_time",        32'(r.wait_time),        32'(data[78:58]));
      check_field("turnaround_time",  32'(r.turnaround_time),  32'(data[99:79]));
      check_field("total_wait",       32'(r.total_wait),       32'(data[124:100]));
      check_field("total_turnaround", 32'(r.total_turnaround), 32'(data[149:125]));
      check_field("pad",              '0,                      32'(data[OUT_W-1:150]));
      check_field("last_result",      32'(r.last),             32'(last));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  schedule_board board = new();
  bit            calm = 0;     // when set, neither side idles
  int            stored = 0;   // jobs the block actually keeps

  always #4 clk = ~clk;

  sjf_nonpreemptive_scheduler_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one job and hold it until the block takes it; returns at that edge.
  task automatic send_job(logic [ID_W-1:0] id, logic [ARR_W-1:0] arr,
                          logic [BST_W-1:0] bst, logic last);
    int gap;
    gap = next_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  <= {bst, arr, id};
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    board.note_job(id, arr, bst, last);
  endtask

  // Drop valid and hold off until every owed slot has come out.
  task automatic drain_outputs();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  // One set of random jobs: mostly small sets, arrivals crowded or spread,
  // sometimes full range values, now and then more jobs than fit.
  task automatic random_set();
    int n;
    int r;
    int arr_hi;
    int bst_hi;
    r = $urandom_range(0, 9);
    if (r < 7)
      n = $urandom_range(1, 6);
    else if (r < 9)
      n = $urandom_range(7, JOBS);
    else
      n = $urandom_range(JOBS + 1, JOBS + 3);
    case ($urandom_range(0, 2))
      0: arr_hi = 20;
      1: arr_hi = 300;
      default: arr_hi = 65535;
    endcase
    case ($urandom_range(0, 2))
      0: bst_hi = 8;
      1: bst_hi = 120;
      default: bst_hi = 65535;
    endcase
    calm = ($urandom_range(0, 5) == 0);
    for (int i = 0; i < n; i++)
      send_job(ID_W'($urandom_range(0, 65535)), ARR_W'($urandom_range(0, arr_hi)),
               BST_W'($urandom_range(0, bst_hi)), i == n - 1);
    stored += (n > JOBS) ? JOBS : n;
  endtask

  // Receiver: random stalls between accepted slots.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        hold = next_gap();
      end
    end
  end

  // Check every output transaction at the edge that moves it.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_slot(m_axis_tdata, m_axis_tlast);
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("** sjf_nonpreemptive_scheduler_top: FAILED **");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Lone job with every field at its top value: idle jump to 65535.
    send_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);

    // Zero burst first, then burst ties broken by arrival, then by input order.
    send_job(16'h0000, 16'd0, 16'd0, 1'b0);
    send_job(16'd1,    16'd0, 16'd5, 1'b0);
    send_job(16'd2,    16'd2, 16'd3, 1'b0);
    send_job(16'd3,    16'd1, 16'd3, 1'b0);
    send_job(16'd4,    16'd1, 16'd3, 1'b1);

    // Idle processor before every job: the clock must jump to the next arrival.
    send_job(16'd10, 16'd100, 16'd4,  1'b0);
    send_job(16'd11, 16'd5,   16'd50, 1'b0);
    send_job(16'd12, 16'd500, 16'd1,  1'b1);

    // Capacity: a full store, then an extra job marked last that is dropped
    // but still starts the schedule.
    for (int i = 0; i < JOBS; i++)
      send_job(ID_W'($urandom_range(0, 65535)), ARR_W'($urandom_range(0, 65535)),
               BST_W'($urandom_range(0, 65535)), 1'b0);
    send_job(16'hBEEF, 16'd0, 16'd1, 1'b1);
    stored = 9 + JOBS;

    // Hold the sender until every owed slot is out.
    drain_outputs();

    while (stored < 110) begin
      random_set();
      if ($urandom_range(0, 7) == 0)
        drain_outputs();
    end
    calm = 0;

    drain_outputs();
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("** sjf_nonpreemptive_scheduler_top: PASSED **");
    else
      $display("** sjf_nonpreemptive_scheduler_top: FAILED **");
    $finish;
  end

endmodule
